// ===== src/srct_pkg.sv =====
// package: sizes, codes and word types of the segment reassembly context table
`default_nettype none
package srct_pkg;

  localparam int NUM_SLOTS     = 10;
  localparam int NUM_BLOCK_IDS = 16;
  localparam int MAX_MSG_BYTES = 4096;

  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int BID_W     = $clog2(NUM_BLOCK_IDS);
  localparam int LEN_W     = $clog2(MAX_MSG_BYTES + 1);
  localparam int SUM_W     = 17;
  localparam int RAM_DEPTH = NUM_SLOTS * NUM_BLOCK_IDS;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  localparam logic [1:0] SZ_BYTE      = 2'h1;
  localparam logic [1:0] SZ_WORD      = 2'h2;
  localparam logic [1:0] BS_COMPLETE  = 2'h0;
  localparam logic [1:0] BS_SEGMENTED = 2'h1;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_DISCARDED = 3'd2,
    ST_NO_SLOT   = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_CALC,
    S_RELCHK
  } state_t;

  typedef struct packed {
    logic [15:0] conn_handle;
    logic [15:0] channel_id;
    logic [7:0]  header_byte;
    logic [15:0] length_field;
  } seg_in_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot_index;
    logic [3:0]  block_id;
    logic [15:0] seg_length;
    logic [12:0] write_offset;
    logic [12:0] message_length;
    logic        slot_released;
  } seg_out_t;

endpackage
`default_nettype wire

// ===== src/srct_ram.sv =====
// generic single-write, registered-read ram
`default_nettype none
module srct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/segment_reassembly_context_table.sv =====
// top level: slot lookup, block length update and release check of the reassembly table
// sequence: a scan of k slots, k = slots scanned
// (1..NUM_SLOTS, one slot a cycle on the shared comparator), then read, update, release check
// a miss (no slot, or a discard without a match) scans all slots and skips read and update
// a new word is taken only back in idle, not while one is in work; busy stays high meanwhile
// reset clears all tags and length valid bits at once; results cannot be stalled
`default_nettype none
module segment_reassembly_context_table (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire srct_pkg::seg_in_t item,
  output logic                   busy,
  output logic                   done,
  output srct_pkg::seg_out_t     result
);

  srct_pkg::state_t state, state_next;

  logic [15:0] tag_h [srct_pkg::NUM_SLOTS];
  logic [15:0] tag_c [srct_pkg::NUM_SLOTS];
  logic [srct_pkg::NUM_BLOCK_IDS-1:0] nz [srct_pkg::NUM_SLOTS];

  logic [15:0]                  req_h;
  logic [15:0]                  req_c;
  logic [srct_pkg::BID_W-1:0]   bid;
  logic [15:0]                  seg;
  logic                         is_append;
  logic                         is_complete;
  logic                         chk_rel;
  logic [srct_pkg::SLOT_W-1:0]  idx;
  logic [srct_pkg::SLOT_W-1:0]  slot;
  logic [srct_pkg::SLOT_W-1:0]  free_idx;
  logic                         free_found;

  logic [1:0]  in_size;
  logic [1:0]  in_bst;
  logic [15:0] in_seg;
  logic        in_append;

  logic                        tag_hit;
  logic                        tag_free;
  logic                        last;
  logic                        scan_end;
  logic                        found_now;
  logic [srct_pkg::SLOT_W-1:0] pick;

  logic [srct_pkg::LEN_W-1:0]  rd_data;
  logic [srct_pkg::LEN_W-1:0]  old;
  logic [srct_pkg::SUM_W-1:0]  sum;
  logic                        ovf;
  logic                        ram_we;
  logic [srct_pkg::RAM_AW-1:0] ram_addr;

  logic do_load;
  logic do_scan;
  logic do_calc;
  logic do_relchk;

  // header decode
  always_comb begin
    in_size   = item.header_byte[7:6];
    in_bst    = item.header_byte[1:0];
    in_append = (in_bst == srct_pkg::BS_COMPLETE) || (in_bst == srct_pkg::BS_SEGMENTED);
    case (in_size)
      srct_pkg::SZ_BYTE: in_seg = {8'h00, item.length_field[7:0]};
      srct_pkg::SZ_WORD: in_seg = item.length_field;
      default:           in_seg = 16'h0000;
    endcase
  end

  // shared tag comparator
  always_comb begin
    tag_hit   = (tag_h[idx] == req_h) && (tag_c[idx] == req_c);
    tag_free  = (tag_h[idx] == 16'h0000) && (tag_c[idx] == 16'h0000);
    last      = (idx == srct_pkg::SLOT_W'(srct_pkg::NUM_SLOTS - 1));
    scan_end  = tag_hit || last;
    found_now = tag_hit || (is_append && (free_found || tag_free));
    if (tag_hit) begin
      pick = idx;
    end else if (free_found) begin
      pick = free_idx;
    end else begin
      pick = idx;
    end
  end

  // length arithmetic
  always_comb begin
    old      = nz[slot][bid] ? rd_data : '0;
    sum      = srct_pkg::SUM_W'(old) + srct_pkg::SUM_W'(seg);
    ovf      = sum > srct_pkg::SUM_W'(srct_pkg::MAX_MSG_BYTES);
    ram_we   = do_calc && is_append && !ovf;
    ram_addr = srct_pkg::RAM_AW'({slot, bid});
  end

  srct_ram #(
    .WIDTH (srct_pkg::LEN_W),
    .DEPTH (srct_pkg::RAM_DEPTH)
  ) u_len_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (srct_pkg::LEN_W'(sum)),
    .raddr (ram_addr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srct_pkg::S_IDLE: begin
        if (start) begin
          state_next = srct_pkg::S_SCAN;
        end
      end
      srct_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = found_now ? srct_pkg::S_READ : srct_pkg::S_RELCHK;
        end
      end
      srct_pkg::S_READ:   state_next = srct_pkg::S_CALC;
      srct_pkg::S_CALC:   state_next = srct_pkg::S_RELCHK;
      srct_pkg::S_RELCHK: state_next = srct_pkg::S_IDLE;
      default:            state_next = srct_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy      = 1'b1;
    do_load   = 1'b0;
    do_scan   = 1'b0;
    do_calc   = 1'b0;
    do_relchk = 1'b0;
    case (state)
      srct_pkg::S_IDLE: begin
        busy    = 1'b0;
        do_load = start;
      end
      srct_pkg::S_SCAN:   do_scan   = 1'b1;
      srct_pkg::S_READ:   ;
      srct_pkg::S_CALC:   do_calc   = 1'b1;
      srct_pkg::S_RELCHK: do_relchk = 1'b1;
      default:            ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= srct_pkg::S_IDLE;
      done    <= 1'b0;
      chk_rel <= 1'b0;
      for (int i = 0; i < srct_pkg::NUM_SLOTS; i++) begin
        tag_h[i] <= '0;
        tag_c[i] <= '0;
        nz[i]    <= '0;
      end
    end else begin
      state <= state_next;
      done  <= do_relchk;
      if (do_load) begin
        chk_rel <= 1'b0;
      end
      if (do_calc) begin
        if (is_append) begin
          tag_h[slot] <= req_h;
          tag_c[slot] <= req_c;
        end
        if (!is_append || ovf || is_complete) begin
          nz[slot][bid] <= 1'b0;
          chk_rel       <= 1'b1;
        end else begin
          nz[slot][bid] <= (sum != '0);
          chk_rel       <= 1'b0;
        end
      end
      if (do_relchk && chk_rel && (nz[slot] == '0)) begin
        tag_h[slot] <= '0;
        tag_c[slot] <= '0;
      end
    end
  end

  // request, scan and result registers
  always_ff @(posedge clk) begin
    if (do_load) begin
      req_h       <= item.conn_handle;
      req_c       <= item.channel_id;
      bid         <= item.header_byte[5:2];
      seg         <= in_seg;
      is_append   <= in_append;
      is_complete <= (in_bst == srct_pkg::BS_COMPLETE);
      idx         <= '0;
      free_found  <= 1'b0;
      result.status         <= in_append ? srct_pkg::ST_NO_SLOT : srct_pkg::ST_DISCARDED;
      result.slot_index     <= 4'h0;
      result.block_id       <= item.header_byte[5:2];
      result.seg_length     <= in_seg;
      result.write_offset   <= 13'h0000;
      result.message_length <= 13'h0000;
      result.slot_released  <= 1'b0;
    end
    if (do_scan) begin
      idx <= idx + 1'b1;
      if (tag_free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if (scan_end) begin
        slot <= pick;
        if (found_now) begin
          result.slot_index <= 4'(pick);
        end
      end
    end
    if (do_calc && is_append) begin
      if (ovf) begin
        result.status <= srct_pkg::ST_OVERFLOW;
      end else begin
        result.status         <= is_complete ? srct_pkg::ST_COMPLETE : srct_pkg::ST_APPENDED;
        result.write_offset   <= 13'(old);
        result.message_length <= 13'(sum);
      end
    end
    if (do_relchk && chk_rel && (nz[slot] == '0)) begin
      result.slot_released <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/srct_checker.sv =====
// port-level checker for the segment reassembly context table, with its bind
`default_nettype none
module srct_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire srct_pkg::seg_out_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("not busy after an accepted word");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result words back to back");

  a_release_status: assert property (@(posedge clk) disable iff (rst)
    done && result.slot_released |->
      result.status != srct_pkg::ST_APPENDED && result.status != srct_pkg::ST_NO_SLOT)
    else $error("slot released without a freed block");

  a_no_len_on_fail: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == srct_pkg::ST_NO_SLOT || result.status == srct_pkg::ST_DISCARDED
      || result.status == srct_pkg::ST_OVERFLOW) |->
      result.write_offset == 13'h0000 && result.message_length == 13'h0000)
    else $error("lengths reported on a failed word");

endmodule

bind segment_reassembly_context_table srct_checker u_srct_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire
